### hdl/plc_pkg.sv
// Shared constants and types for the polyline length compare unit.
package plc_pkg;

  localparam int unsigned CoordBitsDef = 16;
  localparam int unsigned FracBitsDef  = 16;
  localparam int unsigned CoordPortW   = 16;
  localparam int unsigned LenW         = 43;
  localparam int unsigned TolW         = 16;
  localparam logic [TolW-1:0] TolReset = 16'd655;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_ACC,
    ST_FINISH
  } plc_state_e;

endpackage

### hdl/plc_sqrt.sv
// Bit-serial integer square root of a radicand scaled by 2^(2*FRAC_BITS).
module plc_sqrt import plc_pkg::*; #(
  parameter int unsigned RAD_W     = 33,
  parameter int unsigned FRAC_BITS = FracBitsDef,
  parameter int unsigned ROOT_W    = 33
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int unsigned ScaledW = 2 * ROOT_W;
  localparam int unsigned RemW    = ROOT_W + 2;
  localparam int unsigned CntW    = (ROOT_W > 1) ? $clog2(ROOT_W) : 1;

  logic [ScaledW-1:0] rad_q, rad_d;
  logic [RemW-1:0]    rem_q, rem_d;
  logic [ROOT_W-1:0]  root_q, root_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;

  logic [RemW-1:0] rem_shift;
  logic [RemW-1:0] trial;

  always_comb begin
    rem_shift = {rem_q[RemW-3:0], rad_q[ScaledW-1 -: 2]};
    trial     = {root_q, 2'b01};
    rad_d     = rad_q;
    rem_d     = rem_q;
    root_d    = root_q;
    cnt_d     = cnt_q;
    busy_d    = busy_q;
    done_d    = 1'b0;
    if (start_i) begin
      rad_d  = ScaledW'(rad_i) << (2 * FRAC_BITS);
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CntW'(ROOT_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // one root bit per cycle: bring down the next radicand pair, try the subtract
      rad_d = rad_q << 2;
      if (rem_shift >= trial) begin
        rem_d  = rem_shift - trial;
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_shift;
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

### hdl/polyline_length_compare_unit.sv
// Polyline length compare unit: sums segment lengths of two paths and compares them.
//
// Input channel (in_valid_i / in_ready_o): one word per point, tagged with
// path_sel_i and last_point_i. Output channel (out_valid_o / out_ready_i):
// one word after the last point of the second path, carrying both lengths
// and paths_match_o. cfg_we_i writes the match tolerance at any clock edge.
//
// Points are handled one at a time. A point with no previous point passes
// through ST_FINISH before in_ready_o rises again. A point with a previous
// point passes through ST_SQUARE, ST_SUM, ST_ROOT, ST_ACC and ST_FINISH;
// its time is set by the bit-serial square root, which resolves ROOT_W root
// bits, one per cycle; ROOT_W = min(COORD_BITS,16) + FRAC_BITS + 1.
//
// The result sits in an output register, so the next point is accepted while
// a result waits. If the receiver stalls and a new result is ready, the unit
// holds that result internally and accepts no point until the register frees.
// Reset clears the sums, the previous point and the output valid, and sets
// the tolerance to 655 (about 0.01).
module polyline_length_compare_unit import plc_pkg::*; #(
  parameter int unsigned COORD_BITS = CoordBitsDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [TolW-1:0]       cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  path_sel_i,
  input  logic [CoordPortW-1:0] x_i,
  input  logic [CoordPortW-1:0] y_i,
  input  logic                  last_point_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  paths_match_o,
  output logic [LenW-1:0]       length_first_o,
  output logic [LenW-1:0]       length_second_o
);

  localparam int unsigned CoordW = (COORD_BITS < CoordPortW) ? COORD_BITS : CoordPortW;
  localparam int unsigned RadW   = 2 * CoordW + 1;
  localparam int unsigned RootW  = CoordW + FRAC_BITS + 1;
  localparam int unsigned SumW   = COORD_BITS + FRAC_BITS + 11;

  plc_state_e state_q, state_d;

  logic [TolW-1:0]     tol_q, tol_d;
  logic [CoordW-1:0]   prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic                have_prev_q, have_prev_d;
  logic [SumW-1:0]     sum_a_q, sum_a_d, sum_b_q, sum_b_d;
  logic [CoordW-1:0]   dx_q, dx_d, dy_q, dy_d;
  logic [2*CoordW-1:0] sq_x_q, sq_x_d, sq_y_q, sq_y_d;
  logic                sel_q, sel_d, last_q, last_d;
  logic                out_valid_q, out_valid_d;
  logic                match_q, match_d;
  logic [LenW-1:0]     len_a_q, len_a_d, len_b_q, len_b_d;

  logic [CoordW-1:0] x_m, y_m;
  logic              root_start;
  logic [RadW-1:0]   radicand;
  logic              root_done;
  logic [RootW-1:0]  root;
  logic [SumW:0]     acc_sum;
  logic [SumW-1:0]   len_diff;

  assign x_m      = x_i[CoordW-1:0];
  assign y_m      = y_i[CoordW-1:0];
  assign radicand = RadW'(sq_x_q) + RadW'(sq_y_q);
  assign acc_sum  = (sel_q ? {1'b0, sum_b_q} : {1'b0, sum_a_q}) + (SumW + 1)'(root);
  assign len_diff = (sum_a_q >= sum_b_q) ? (sum_a_q - sum_b_q) : (sum_b_q - sum_a_q);

  plc_sqrt #(
    .RAD_W    (RadW),
    .FRAC_BITS(FRAC_BITS),
    .ROOT_W   (RootW)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(root_start),
    .rad_i  (radicand),
    .done_o (root_done),
    .root_o (root)
  );

  always_comb begin
    state_d     = state_q;
    tol_d       = cfg_we_i ? cfg_wdata_i : tol_q;
    prev_x_d    = prev_x_q;
    prev_y_d    = prev_y_q;
    have_prev_d = have_prev_q;
    sum_a_d     = sum_a_q;
    sum_b_d     = sum_b_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    sq_x_d      = sq_x_q;
    sq_y_d      = sq_y_q;
    sel_d       = sel_q;
    last_d      = last_q;
    match_d     = match_q;
    len_a_d     = len_a_q;
    len_b_d     = len_b_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    root_start  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          dx_d        = (x_m >= prev_x_q) ? (x_m - prev_x_q) : (prev_x_q - x_m);
          dy_d        = (y_m >= prev_y_q) ? (y_m - prev_y_q) : (prev_y_q - y_m);
          prev_x_d    = x_m;
          prev_y_d    = y_m;
          have_prev_d = !last_point_i;
          sel_d       = path_sel_i;
          last_d      = last_point_i;
          state_d     = have_prev_q ? ST_SQUARE : ST_FINISH;
        end
      end
      ST_SQUARE: begin
        sq_x_d  = dx_q * dx_q;
        sq_y_d  = dy_q * dy_q;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        root_start = 1'b1;
        state_d    = ST_ROOT;
      end
      ST_ROOT: begin
        if (root_done) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        // saturate at the top of the sum range
        if (sel_q) begin
          sum_b_d = acc_sum[SumW] ? '1 : acc_sum[SumW-1:0];
        end else begin
          sum_a_d = acc_sum[SumW] ? '1 : acc_sum[SumW-1:0];
        end
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!(last_q && sel_q)) begin
          state_d = ST_IDLE;
        end else if (!out_valid_q || out_ready_i) begin
          // end of second path: load the result word and start a fresh pair
          match_d     = (len_diff <= SumW'(tol_q));
          len_a_d     = LenW'(sum_a_q);
          len_b_d     = LenW'(sum_b_q);
          out_valid_d = 1'b1;
          sum_a_d     = '0;
          sum_b_d     = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tol_q       <= TolReset;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      have_prev_q <= 1'b0;
      sum_a_q     <= '0;
      sum_b_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tol_q       <= tol_d;
      prev_x_q    <= prev_x_d;
      prev_y_q    <= prev_y_d;
      have_prev_q <= have_prev_d;
      sum_a_q     <= sum_a_d;
      sum_b_q     <= sum_b_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    sq_x_q  <= sq_x_d;
    sq_y_q  <= sq_y_d;
    sel_q   <= sel_d;
    last_q  <= last_d;
    match_q <= match_d;
    len_a_q <= len_a_d;
    len_b_q <= len_b_d;
  end

  assign out_valid_o     = out_valid_q;
  assign paths_match_o   = match_q;
  assign length_first_o  = len_a_q;
  assign length_second_o = len_b_q;

endmodule

### hdl/plc_checker.sv
// Port-level checks for the polyline length compare unit, bound to the top level.
module plc_checker import plc_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_we_i,
  input logic [TolW-1:0]       cfg_wdata_i,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  path_sel_i,
  input logic [CoordPortW-1:0] x_i,
  input logic [CoordPortW-1:0] y_i,
  input logic                  last_point_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic                  paths_match_o,
  input logic [LenW-1:0]       length_first_o,
  input logic [LenW-1:0]       length_second_o
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(paths_match_o)
      && $stable(length_first_o) && $stable(length_second_o))
    else $error("stalled result word changed");

  // one point at a time: an accepted word drops ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after an accepted point");

  // a new result appears only as the unit finishes a point and reopens its input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result appeared while input still busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a point in progress");

endmodule

bind polyline_length_compare_unit plc_checker u_plc_checker (.*);

### bench/tb.sv
// Testbench for the polyline length compare unit: predicted path lengths checked per word.
`timescale 1ns / 1ps

module tb;
  import plc_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int SettleCycles  = 60;
  localparam int HoldCycles    = 400;
  localparam logic [LenW-1:0] LenMax = {LenW{1'b1}};

  typedef struct packed {
    logic                  sel;
    logic [CoordPortW-1:0] x;
    logic [CoordPortW-1:0] y;
    logic                  last;
  } point_t;

  typedef struct packed {
    logic            match;
    logic [LenW-1:0] len_a;
    logic [LenW-1:0] len_b;
  } report_t;

  typedef struct packed {
    logic                  sel;
    logic [CoordPortW-1:0] x;
    logic [CoordPortW-1:0] y;
    logic                  last;
    bit                    typed;
    logic                  match;
    logic [LenW-1:0]       len_a;
    logic [LenW-1:0]       len_b;
  } dir_row_t;

  typedef enum int {SPREAD_WIDE, SPREAD_LOCAL, SPREAD_EDGE} spread_e;

  // sel, x, y, last, typed, match, length A, length B
  localparam dir_row_t DirRows [19] = '{
    '{1'b0, 16'd5,     16'd5,     1'b1, 1'b0, 1'b0, 43'd0,      43'd0},
    '{1'b1, 16'd7,     16'd7,     1'b1, 1'b1, 1'b1, 43'd0,      43'd0},
    '{1'b0, 16'd1,     16'd1,     1'b0, 1'b0, 1'b0, 43'd0,      43'd0},
    '{1'b0, 16'd4,     16'd5,     1'b1, 1'b0, 1'b0, 43'd0,      43'd0},
    '{1'b1, 16'd1,     16'd1,     1'b0, 1'b0, 1'b0, 43'd0,      43'd0},
    '{1'b1, 16'd1,     16'd1,     1'b1, 1'b1, 1'b0, 43'd327680, 43'd0},
    '{1'b0, 16'd0,     16'd0,     1'b0, 1'b0, 1'b0, 43'd0,      43'd0},
    '{1'b0, 16'd65535, 16'd65535, 1'b1, 1'b0, 1'b0, 43'd0,      43'd0},
    '{1'b1, 16'd65535, 16'd0,     1'b0, 1'b0, 1'b0, 43'd0,      43'd0},
    '{1'b1, 16'd0,     16'd65535, 1'b1, 1'b0, 1'b0, 43'd0,      43'd0},
    '{1'b0, 16'd1,     16'd1,     1'b0, 1'b0, 1'b0, 43'd0,      43'd0},
    '{1'b0, 16'd2,     16'd1,     1'b0, 1'b0, 1'b0, 43'd0,      43'd0},
    '{1'b0, 16'd2,     16'd2,     1'b1, 1'b0, 1'b0, 43'd0,      43'd0},
    '{1'b1, 16'd10,    16'd10,    1'b0, 1'b0, 1'b0, 43'd0,      43'd0},
    '{1'b1, 16'd11,    16'd11,    1'b1, 1'b1, 1'b0, 43'd131072, 43'd92681},
    '{1'b0, 16'd3,     16'd3,     1'b0, 1'b0, 1'b0, 43'd0,      43'd0},
    '{1'b1, 16'd6,     16'd7,     1'b0, 1'b0, 1'b0, 43'd0,      43'd0},
    '{1'b0, 16'd6,     16'd8,     1'b0, 1'b0, 1'b0, 43'd0,      43'd0},
    '{1'b1, 16'd6,     16'd8,     1'b1, 1'b0, 1'b0, 43'd0,      43'd0}
  };

  logic                  clk_i;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  logic [TolW-1:0]       cfg_wdata_i     = '0;
  logic                  in_valid_i      = 1'b0;
  logic                  in_ready_o;
  logic                  path_sel_i      = 1'b0;
  logic [CoordPortW-1:0] x_i             = '0;
  logic [CoordPortW-1:0] y_i             = '0;
  logic                  last_point_i    = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i     = 1'b0;
  logic                  paths_match_o;
  logic [LenW-1:0]       length_first_o;
  logic [LenW-1:0]       length_second_o;

  // predictor state
  logic [TolW-1:0]       tolerance = TolReset;
  logic [CoordPortW-1:0] prev_x    = '0;
  logic [CoordPortW-1:0] prev_y    = '0;
  bit                    have_prev = 1'b0;
  logic [LenW-1:0]       sum_a     = '0;
  logic [LenW-1:0]       sum_b     = '0;

  report_t length_report_q[$];
  report_t head_rep;
  int      err_cnt        = 0;
  int      points_sent    = 0;
  int      idle_cycles    = 0;
  int      send_idle_pct  = 0;
  int      recv_stall_pct = 0;
  bit      pressure_req   = 1'b0;

  polyline_length_compare_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .path_sel_i      (path_sel_i),
    .x_i             (x_i),
    .y_i             (y_i),
    .last_point_i    (last_point_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .paths_match_o   (paths_match_o),
    .length_first_o  (length_first_o),
    .length_second_o (length_second_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Truncated root of (dx^2 + dy^2) scaled by 2^(2*frac), one root bit per step.
  function automatic logic [LenW-1:0] segment_length(logic [CoordPortW-1:0] dx,
                                                     logic [CoordPortW-1:0] dy);
    logic [127:0] rad;
    logic [127:0] rem;
    logic [127:0] trial;
    logic [63:0]  root;
    rad  = ({112'd0, dx} * {112'd0, dx} + {112'd0, dy} * {112'd0, dy}) << (2 * FracBitsDef);
    rem  = '0;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      rem   = (rem << 2) | {126'd0, rad[2*i +: 2]};
      trial = ({64'd0, root} << 2) | 128'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = {root[62:0], 1'b1};
      end else begin
        root = {root[62:0], 1'b0};
      end
    end
    return root[LenW-1:0];
  endfunction

  function automatic logic [LenW-1:0] clamp_add(logic [LenW-1:0] a, logic [LenW-1:0] b);
    logic [LenW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LenW] ? LenMax : s[LenW-1:0];
  endfunction

  // Advance the selected path's sum by one point; return 1 when a result word is due.
  function automatic bit advance_paths(input point_t p, output report_t rep);
    logic [CoordPortW-1:0] dx;
    logic [CoordPortW-1:0] dy;
    logic [LenW-1:0]       diff;
    rep = '0;
    if (have_prev) begin
      dx = (p.x >= prev_x) ? p.x - prev_x : prev_x - p.x;
      dy = (p.y >= prev_y) ? p.y - prev_y : prev_y - p.y;
      if (!p.sel) sum_a = clamp_add(sum_a, segment_length(dx, dy));
      else sum_b = clamp_add(sum_b, segment_length(dx, dy));
    end
    prev_x    = p.x;
    prev_y    = p.y;
    have_prev = 1'b1;
    if (!p.last) return 1'b0;
    have_prev = 1'b0;
    if (!p.sel) return 1'b0;
    diff      = (sum_a >= sum_b) ? sum_a - sum_b : sum_b - sum_a;
    rep.match = (diff <= {27'd0, tolerance});
    rep.len_a = sum_a;
    rep.len_b = sum_b;
    sum_a     = '0;
    sum_b     = '0;
    return 1'b1;
  endfunction

  function automatic logic [CoordPortW-1:0] pick_coord(spread_e spread,
                                                       logic [CoordPortW-1:0] base);
    case (spread)
      SPREAD_WIDE:  return CoordPortW'($urandom_range(65535));
      SPREAD_LOCAL: return base ^ CoordPortW'($urandom_range(63));
      default: begin
        case ($urandom_range(3))
          0:       return 16'd0;
          1:       return 16'd1;
          2:       return 16'd65534;
          default: return 16'd65535;
        endcase
      end
    endcase
  endfunction

  // Offer one word and hold it until accepted.
  task automatic send_point(input point_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    path_sel_i   <= p.sel;
    x_i          <= p.x;
    y_i          <= p.y;
    last_point_i <= p.last;
    forever begin
      @(posedge clk_i);
      if (in_ready_o) break;
    end
    points_sent++;
  endtask

  task automatic feed_point(input point_t p);
    report_t rep;
    send_point(p);
    if (advance_paths(p, rep)) length_report_q.push_back(rep);
  endtask

  task automatic send_random_pair();
    point_t                path_a[$];
    point_t                p;
    spread_e               spread;
    logic [CoordPortW-1:0] base;
    int                    n;
    bit                    flip;
    bit                    swap;
    int                    nudge;
    n      = ($urandom_range(9) == 0) ? $urandom_range(20, 7) : $urandom_range(5, 1);
    spread = spread_e'($urandom_range(2));
    base   = CoordPortW'($urandom_range(65535));
    for (int i = 0; i < n; i++) begin
      p.sel  = 1'b0;
      p.x    = pick_coord(spread, base);
      p.y    = pick_coord(spread, base);
      p.last = (i == n - 1);
      path_a.push_back(p);
      feed_point(p);
    end
    if ($urandom_range(99) < 45) begin
      // reorder or mirror the first path so its length is kept, then maybe nudge one point
      flip  = 1'($urandom_range(1));
      swap  = 1'($urandom_range(1));
      nudge = ($urandom_range(1) != 0) ? $urandom_range(n - 1) : -1;
      for (int i = 0; i < n; i++) begin
        p = flip ? path_a[n - 1 - i] : path_a[i];
        if (swap) {p.x, p.y} = {p.y, p.x};
        if (i == nudge) p.x = p.x ^ 16'd1;
        p.sel  = 1'b1;
        p.last = (i == n - 1);
        feed_point(p);
      end
    end else begin
      n = $urandom_range(6, 1);
      for (int i = 0; i < n; i++) begin
        p.sel  = 1'b1;
        p.x    = pick_coord(spread, base);
        p.y    = pick_coord(spread, base);
        p.last = (i == n - 1);
        feed_point(p);
      end
    end
  endtask

  // Stray words: unmarked path switches, lone end marks.
  task automatic send_noise();
    point_t p;
    int     n;
    n = $urandom_range(3, 1);
    repeat (n) begin
      p.sel  = 1'($urandom_range(1));
      p.x    = CoordPortW'($urandom_range(65535));
      p.y    = CoordPortW'($urandom_range(65535));
      p.last = ($urandom_range(9) < 3);
      feed_point(p);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (length_report_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_tolerance(input logic [TolW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tolerance    = value;
  endtask

  task automatic run_phase(input int count, input int send_pct, input int recv_pct);
    int stop_at;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    stop_at        = points_sent + count;
    while (points_sent < stop_at) begin
      if ($urandom_range(9) == 0) send_noise();
      else send_random_pair();
    end
    send_random_pair();
  endtask

  task automatic run_pressure();
    point_t p;
    pressure_req = 1'b1;
    repeat (25) begin
      p = '{1'b0, CoordPortW'($urandom_range(65535)), CoordPortW'($urandom_range(65535)), 1'b1};
      feed_point(p);
      p.sel = 1'b1;
      p.x   = CoordPortW'($urandom_range(65535));
      feed_point(p);
    end
  endtask

  initial begin
    dir_row_t row;
    point_t   p;
    report_t  rep;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table at reset tolerance, no idling
    foreach (DirRows[i]) begin
      row = DirRows[i];
      p   = '{row.sel, row.x, row.y, row.last};
      send_point(p);
      if (advance_paths(p, rep)) begin
        if (row.typed) length_report_q.push_back('{row.match, row.len_a, row.len_b});
        else length_report_q.push_back(rep);
      end
    end
    drain();

    set_tolerance(16'd0);
    run_phase(100, 0, 0);
    drain();
    set_tolerance(16'hFFFF);
    run_phase(100, 60, 0);
    drain();
    set_tolerance(TolW'($urandom_range(65535)));
    run_phase(100, 0, 60);
    drain();
    set_tolerance(TolReset);
    run_phase(60, 35, 35);
    run_pressure();
    run_phase(60, 35, 35);
    drain();

    repeat (100) @(posedge clk_i);
    if (err_cnt == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // result receiver; a pressure request holds ready low for a long stretch
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (pressure_req) begin
        pressure_req = 1'b0;
        hold_left    = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (length_report_q.size() == 0) begin
        $error("result word with nothing expected");
        err_cnt++;
      end else begin
        head_rep = length_report_q.pop_front();
        if (paths_match_o !== head_rep.match) begin
          $error("paths_match: expected %0d, got %0d", head_rep.match, paths_match_o);
          err_cnt++;
        end
        if (length_first_o !== head_rep.len_a) begin
          $error("length_first: expected %0d, got %0d", head_rep.len_a, length_first_o);
          err_cnt++;
        end
        if (length_second_o !== head_rep.len_b) begin
          $error("length_second: expected %0d, got %0d", head_rep.len_b, length_second_o);
          err_cnt++;
        end
      end
    end
  end

  // watchdog: cycles without any accepted word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

endmodule
